// ===== rtl/lcwmf_pkg.sv =====
// Shared widths, codes and types for the load cell weight median filter.
package lcwmf_pkg;

  // Field widths
  localparam int CODE_W    = 24;
  localparam int CAL_W     = 16;
  localparam int WEIGHT_W  = 28;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 32;

  // Defaults of the top-level parameters
  localparam int DEF_WINDOW_LEN = 5;
  localparam int DEF_MIDDLE_POS = 2;

  // Converter and weight constants
  localparam logic [CODE_W-1:0]   SIGN_FLIP    = 24'h800000;
  localparam logic [WEIGHT_W-1:0] GLITCH_VALUE = 28'd11164458;
  localparam logic [CAL_W-1:0]    CAL_RESET    = 16'd6155;   // 384.6875 in Q12.4

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL  = 1'b1;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = WEIGHT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_INS,
    ST_EMIT
  } lcwmf_state_e;

  // Per-cell control for one insertion
  typedef struct packed {
    logic load;     // insertion happens at this edge
    logic used;     // cell holds a live entry
    logic at_fill;  // first free cell
  } lcwmf_cell_ctrl_t;

endpackage

// ===== rtl/lcwmf_div.sv =====
// Restoring divider, one quotient bit per cycle.
module lcwmf_div
  import lcwmf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WEIGHT_W-1:0] dividend_i,
  input  logic [CAL_W-1:0]    divisor_i,
  output logic                done_o,
  output logic [WEIGHT_W-1:0] quotient_o
);

  logic                 active_q, active_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WEIGHT_W-1:0]  quo_q, quo_d;
  logic [CAL_W-1:0]     rem_q, rem_d;
  logic [CAL_W-1:0]     div_q, div_d;
  logic [CAL_W:0]       trial;
  logic [CAL_W:0]       diff;
  logic                 ge;

  localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, quo_q[WEIGHT_W-1]};
  assign ge    = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    div_d    = div_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      quo_d    = dividend_i;
      rem_d    = '0;
      div_d    = divisor_i;
    end else if (active_q) begin
      quo_d = {quo_q[WEIGHT_W-2:0], ge};
      rem_d = ge ? diff[CAL_W-1:0] : trial[CAL_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST_STEP) begin
        active_d = 1'b0;
      end
    end
  end

  // Hold control under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = active_q && (cnt_q == LAST_STEP);
  assign quotient_o = quo_q;

endmodule

// ===== rtl/lcwmf_cell.sv =====
// One cell of the sorted store: keeps an entry and shifts in from its lower neighbour.
module lcwmf_cell
  import lcwmf_pkg::*;
(
  input  logic                clk_i,
  input  lcwmf_cell_ctrl_t    ctrl_i,
  input  logic [WEIGHT_W-1:0] new_i,
  input  logic [WEIGHT_W-1:0] left_entry_i,
  input  logic                left_gt_i,
  output logic [WEIGHT_W-1:0] entry_o,
  output logic                gt_o
);

  logic [WEIGHT_W-1:0] entry_q, entry_d;
  logic                take;

  // Live entry above the new value must make room
  assign gt_o = ctrl_i.used && (entry_q > new_i);
  assign take = ctrl_i.load && (gt_o || (!ctrl_i.used && ctrl_i.at_fill));

  // Take the lower neighbour if it also moves up, else the new value
  always_comb begin
    entry_d = entry_q;
    if (take) begin
      entry_d = left_gt_i ? left_entry_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== rtl/load_cell_weight_median_filter_unit.sv =====
// Top level: weight from converter words, divide by calibration, block median filter.
//
//  channel | dir | handshake                     | payload
//  --------+-----+-------------------------------+-------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: first_code, second_code
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tdata: weight_out; tuser: median_valid
//  cfg     | in  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// An item passes from acceptance through the bit-serial divide (one quotient bit a
// cycle, loaded at the accepting edge), the insertion into the cell row and the load
// of the result; input is taken again after that load. Results give the running max
// until the window closes, then its median. Reset clears the sequencer, fill count,
// tare and valid flags and sets CAL_RESET; data registers and store cells are not
// reset. A stalled result holds; the next item is taken while the result waits.
module load_cell_weight_median_filter_unit
  import lcwmf_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN,
  parameter int MIDDLE_POS = DEF_MIDDLE_POS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [23:0] first_code, [47:24] second_code
  // stream out
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [27:0] weight_out, [31:28] zero
  output logic                  m_axis_tuser,   // [0] median_valid
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CODE_W-1:0]     cfg_data_i
);

  localparam int FILL_W = $clog2(WINDOW_LEN);
  localparam int MID    = (MIDDLE_POS < WINDOW_LEN) ? MIDDLE_POS : WINDOW_LEN - 1;
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);

  lcwmf_state_e          state_q, state_d;
  logic [CODE_W-1:0]     tare_q, tare_d;
  logic [CAL_W-1:0]      cal_q, cal_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [WEIGHT_W-1:0]   max_q, max_d;
  logic                  zero_q, zero_d;
  logic                  out_valid_q, out_valid_d;
  logic [WEIGHT_W-1:0]   out_weight_q, out_weight_d;
  logic                  out_median_q, out_median_d;

  logic                  in_acc;
  logic [CODE_W-1:0]     code1, code2, diff;
  logic                  div_start, div_done;
  logic [WEIGHT_W-1:0]   dividend, quotient, weight;
  logic                  cells_load;

  logic [WEIGHT_W-1:0]   entry [WINDOW_LEN];
  logic                  gt    [WINDOW_LEN];

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    tare_d = tare_q;
    cal_d  = cal_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TARE: tare_d = cfg_data_i;
        CFG_CAL:  cal_d  = cfg_data_i[CAL_W-1:0];
        default:  ;
      endcase
    end
  end

  // Offset-binary codes and tare difference
  assign code1    = s_axis_tdata[CODE_W-1:0] ^ SIGN_FLIP;
  assign code2    = s_axis_tdata[2*CODE_W-1:CODE_W] ^ SIGN_FLIP;
  assign diff     = (code2 > tare_q) ? (code2 - tare_q) : '0;
  assign dividend = {diff, 4'b0000};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign div_start     = in_acc;

  lcwmf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (cal_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Drop the glitch value and gated readings
  assign weight = (zero_q || (quotient == GLITCH_VALUE)) ? '0 : quotient;

  // Row of store cells
  generate
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
      lcwmf_cell_ctrl_t    ctrl;
      logic [WEIGHT_W-1:0] left_entry;
      logic                left_gt;

      assign ctrl.load    = cells_load;
      assign ctrl.used    = (FILL_W'(k) < fill_q);
      assign ctrl.at_fill = (FILL_W'(k) == fill_q);

      if (k == 0) begin : g_first
        assign left_entry = '0;
        assign left_gt    = 1'b0;
      end else begin : g_rest
        assign left_entry = entry[k-1];
        assign left_gt    = gt[k-1];
      end

      lcwmf_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .new_i        (weight),
        .left_entry_i (left_entry),
        .left_gt_i    (left_gt),
        .entry_o      (entry[k]),
        .gt_o         (gt[k])
      );
    end
  endgenerate

  // Sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    max_d        = max_q;
    zero_d       = zero_q;
    out_valid_d  = out_valid_q;
    out_weight_d = out_weight_q;
    out_median_d = out_median_q;
    cells_load   = 1'b0;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          zero_d  = (code1 <= tare_q);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        cells_load = 1'b1;
        max_d      = ((fill_q == '0) || (weight > max_q)) ? weight : max_q;
        fill_d     = (fill_q == FILL_LAST) ? '0 : fill_q + 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        // Fill count back at zero means the window just closed
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d  = 1'b1;
          out_median_d = (fill_q == '0);
          out_weight_d = (fill_q == '0) ? entry[MID] : max_q;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tare_q      <= '0;
      cal_q       <= CAL_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tare_q      <= tare_d;
      cal_q       <= cal_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    max_q        <= max_d;
    zero_q       <= zero_d;
    out_weight_q <= out_weight_d;
    out_median_q <= out_median_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-WEIGHT_W){1'b0}}, out_weight_q};
  assign m_axis_tuser  = out_median_q;

endmodule

// ===== rtl/lcwmf_checker.sv =====
// Port-level checks for the median filter top level, with its bind.
module lcwmf_checker
  import lcwmf_pkg::*;
#(
  parameter int WINDOW_LEN = DEF_WINDOW_LEN
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  localparam int CNT_W = $clog2(WINDOW_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

  logic                s_acc, m_acc;
  logic [CNT_W-1:0]    cnt_q;
  logic [WEIGHT_W-1:0] last_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;

  // Track the place of each result within its window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= '0;
    end else if (m_acc) begin
      cnt_q  <= (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
      last_q <= m_axis_tdata[WEIGHT_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input taken again while dividing");

  a_median_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc |-> (m_axis_tuser == (cnt_q == CNT_LAST)))
    else $error("median flag out of step with window");

  a_max_rises: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_acc && !m_axis_tuser && (cnt_q != '0) |-> (m_axis_tdata[WEIGHT_W-1:0] >= last_q))
    else $error("running maximum fell within a window");

endmodule

bind load_cell_weight_median_filter_unit lcwmf_checker #(
  .WINDOW_LEN(WINDOW_LEN)
) u_lcwmf_checker (.*);

// ===== tb/sv/tb_load_cell_weight_median_filter_unit.sv =====
// Testbench: load cell weight median filter, checked item by item against a local predictor.
`timescale 1ns / 1ps

module tb_load_cell_weight_median_filter_unit;
  import lcwmf_pkg::*;

  localparam int WINDOW        = DEF_WINDOW_LEN;
  localparam int MIDDLE        = DEF_MIDDLE_POS;
  localparam int MID_SEL       = (MIDDLE < WINDOW) ? MIDDLE : WINDOW - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 250;
  localparam int HOLD_AFTER    = 330;    // results seen before the long hold-off
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 92;
  localparam int DIR_ROWS      = 26;
  localparam logic [CODE_W-1:0] CODE_MAX  = '1;
  localparam logic [CODE_W-1:0] GLITCH_C2 = 24'hAA5B2A;  // code distance equal to the glitch

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  // One row of the directed table; second carries the write data on register rows
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CODE_W-1:0]     first;
    logic [CODE_W-1:0]     second;
    logic                  typed;
    logic [WEIGHT_W-1:0]   w;
    logic                  mv;
  } stim_row_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] w;
    logic                mv;
  } weight_result_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [23:0] first_code, [47:24] second_code
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;         // [27:0] weight_out, [31:28] zero
  logic                  m_axis_tuser;         // [0] median_valid
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = CFG_TARE;
  logic [CODE_W-1:0]     cfg_data_i    = '0;

  // Predictor state
  logic [CODE_W-1:0]   tare_q = '0;
  logic [CAL_W-1:0]    cal_q  = CAL_RESET;
  logic [WEIGHT_W-1:0] sorted_w [WINDOW];
  int                  fill_n = 0;

  weight_result_t pending_results[$];
  int             error_count    = 0;
  int             results_seen   = 0;
  int             src_gap_max    = 12;
  int             snk_gap_max    = 12;
  bit             long_hold_done = 1'b0;

  // Directed table: typed expectations only where they are obvious
  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset values: first code at zero is never above the tare
    '{ROW_ITEM, CFG_TARE, 24'h800000, 24'hFFFFFF, 1'b1, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000000, 24'h7FFFFF, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h7FFFFF, 24'h800000, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'hFFFFFF, 24'h000000, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h123456, 24'hABCDEF, 1'b0, 28'd0, 1'b0},
    // zero divisor saturates the weight
    '{ROW_CFG,  CFG_CAL,  24'h000000, 24'h000000, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000001, 24'h5A5A5A, 1'b1, 28'hFFFFFFF, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h800000, 24'hFFFFFF, 1'b1, 28'hFFFFFFF, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h7FFFFF, 24'h800000, 1'b1, 28'hFFFFFFF, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h3C3C3C, 24'hC3C3C3, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000000, 24'h000000, 1'b0, 28'd0, 1'b0},
    // divisor of one unit: the glitch weight and its neighbours
    '{ROW_CFG,  CFG_CAL,  24'h000000, 24'h000010, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000000, 24'h2A5B2A, 1'b1, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000000, 24'h2A5B2B, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000000, 24'h2A5B29, 1'b0, 28'd0, 1'b0},
    // tare and divisor at their maximum
    '{ROW_CFG,  CFG_TARE, 24'h000000, 24'hFFFFFF, 1'b0, 28'd0, 1'b0},
    '{ROW_CFG,  CFG_CAL,  24'h000000, 24'h00FFFF, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 28'd0, 1'b0},
    // mid tare, smallest divisor written with junk in the upper bits
    '{ROW_CFG,  CFG_TARE, 24'h000000, 24'h800000, 1'b0, 28'd0, 1'b0},
    '{ROW_CFG,  CFG_CAL,  24'h000000, 24'hFF0001, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h7FFFFF, 24'h000000, 1'b1, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h7FFFFF, 24'h7FFFFF, 1'b1, 28'h7FFFFF0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h800001, 24'h7FFFFF, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h7FFFFF, 24'h000001, 1'b0, 28'd0, 1'b0},
    '{ROW_ITEM, CFG_TARE, 24'h000000, 24'hAAAAAA, 1'b0, 28'd0, 1'b0}
  };

  load_cell_weight_median_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Weight from the two words, then insertion into the sorted window
  function automatic void predict_filtered_weight(input logic [CODE_W-1:0] first_raw,
                                                  input logic [CODE_W-1:0] second_raw,
                                                  output weight_result_t res);
    logic [CODE_W-1:0]   c1;
    logic [CODE_W-1:0]   c2;
    logic [CODE_W-1:0]   diff;
    logic [31:0]         quot;
    logic [WEIGHT_W-1:0] carry;
    logic [WEIGHT_W-1:0] swap;
    c1 = first_raw ^ SIGN_FLIP;
    c2 = second_raw ^ SIGN_FLIP;
    res.mv = 1'b0;
    if (c1 <= tare_q) begin
      carry = '0;
    end else if (cal_q == '0) begin
      carry = '1;
    end else begin
      diff  = (c2 > tare_q) ? c2 - tare_q : '0;
      quot  = {4'd0, diff, 4'd0} / {16'd0, cal_q};
      carry = quot[WEIGHT_W-1:0];
      if (carry == GLITCH_VALUE) carry = '0;
    end
    if (fill_n >= WINDOW) fill_n = 0;
    // carry the larger value upward; it lands in the first free slot
    for (int k = 0; k < fill_n; k++) begin
      if (sorted_w[k] > carry) begin
        swap        = sorted_w[k];
        sorted_w[k] = carry;
        carry       = swap;
      end
    end
    sorted_w[fill_n] = carry;
    fill_n++;
    if (fill_n >= WINDOW) begin
      carry  = sorted_w[MID_SEL];
      res.mv = 1'b1;
      fill_n = 0;
    end
    res.w = carry;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Offer one item after a random gap; predict once it is taken
  task automatic send_item(input logic [CODE_W-1:0] first_raw, input logic [CODE_W-1:0] second_raw,
                           input bit typed, input logic [WEIGHT_W-1:0] typed_w, input bit typed_mv);
    int             gap;
    weight_result_t predicted;
    gap = $urandom_range(0, src_gap_max);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {second_raw, first_raw};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    predict_filtered_weight(first_raw, second_raw, predicted);
    if (typed) predicted = '{w: typed_w, mv: typed_mv};
    pending_results.push_back(predicted);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_TARE: tare_q = data;
      CFG_CAL:  cal_q  = data[CAL_W-1:0];
      default:  ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop the input, wait for every expected item and let the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Code above a floor most of the time, otherwise any code
  function automatic logic [CODE_W-1:0] draw_code(input logic [CODE_W-1:0] floor_c);
    if (floor_c != CODE_MAX && $urandom_range(0, 3) != 0)
      return CODE_W'($urandom_range(32'(floor_c) + 1, 32'(CODE_MAX)));
    return CODE_W'($urandom);
  endfunction

  // Result side: random stall per item, one long hold-off
  initial begin : result_sink
    int stall;
    weight_result_t want;
    forever begin
      stall = $urandom_range(0, snk_gap_max);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        stall          = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      repeat (stall) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item, weight %0d", m_axis_tdata[WEIGHT_W-1:0]));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[WEIGHT_W-1:0] !== want.w)
          report_mismatch($sformatf("weight_out %0d, want %0d",
                                    m_axis_tdata[WEIGHT_W-1:0], want.w));
        if (m_axis_tdata[OUT_DATA_W-1:WEIGHT_W] !== '0)
          report_mismatch($sformatf("tdata padding %h not zero",
                                    m_axis_tdata[OUT_DATA_W-1:WEIGHT_W]));
        if (m_axis_tuser !== want.mv)
          report_mismatch($sformatf("median_valid %b, want %b", m_axis_tuser, want.mv));
      end
    end
  end

  // Stimulus: directed table, then random phases under changing settings
  initial begin : stimulus
    logic [CODE_W-1:0] tare_val;
    logic [CODE_W-1:0] cal_data;
    logic [CODE_W-1:0] c1;
    logic [CODE_W-1:0] c2;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].second);
      end else begin
        send_item(dir_rows[i].first, dir_rows[i].second, dir_rows[i].typed,
                  dir_rows[i].w, dir_rows[i].mv);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      tare_val = CODE_W'($urandom);
      cal_data = CODE_W'($urandom_range(1, 65535));
      case (ph)
        0: begin
          tare_val = '0;
          cal_data = 24'd1;
          src_gap_max = 0;  snk_gap_max = 0;
        end
        1: begin
          tare_val = CODE_W'($urandom_range(32'h7F0000, 32'h810000));
          cal_data = {8'd0, CAL_RESET};
          src_gap_max = 12; snk_gap_max = 12;
        end
        2: begin
          tare_val = 24'hFFFFF0;
          cal_data = 24'h00FFFF;
          src_gap_max = 0;  snk_gap_max = 12;
        end
        3: begin
          cal_data = CODE_W'($urandom);
          src_gap_max = 12; snk_gap_max = 0;
        end
        4: begin
          tare_val = CODE_W'($urandom_range(0, 32'h550000));
          cal_data = 24'd16;
          src_gap_max = 3;  snk_gap_max = 3;
        end
        5: begin
          cal_data = '0;
          src_gap_max = 12; snk_gap_max = 12;
        end
        6: begin
          cal_data = CODE_W'($urandom_range(1, 64));
          src_gap_max = 0;  snk_gap_max = 0;
        end
        default: begin
          src_gap_max = 12; snk_gap_max = 12;
        end
      endcase
      write_reg(CFG_TARE, tare_val);
      write_reg(CFG_CAL, cal_data);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c1 = draw_code(tare_val);
        c2 = draw_code(tare_val);
        // hit the glitch weight now and then when the divisor is one unit
        if (cal_data == 24'd16 && $urandom_range(0, 7) == 0) c2 = tare_val + GLITCH_C2;
        send_item(c1 ^ SIGN_FLIP, c2 ^ SIGN_FLIP, 1'b0, '0, 1'b0);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lcwmf_pkg.sv
rtl/lcwmf_div.sv
rtl/lcwmf_cell.sv
rtl/load_cell_weight_median_filter_unit.sv
rtl/lcwmf_checker.sv
tb/sv/tb_load_cell_weight_median_filter_unit.sv
